/* hw/rtl/mra_pkg.sv */
// Shared types, microcode program and dispatch tables for the residue ALU.
package mra_pkg;

   // Sequencer step address width
   localparam int STEP_W = 5;

   // Operation codes carried in the mode field
   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_POW = 3'd3;
   localparam logic [2:0] MODE_INV = 3'd4;
   localparam logic [2:0] MODE_DIV = 3'd5;

   // Microprogram step addresses
   localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] S_RED_A    = 5'd1;
   localparam logic [STEP_W-1:0] S_RED_B    = 5'd2;
   localparam logic [STEP_W-1:0] S_ADD      = 5'd3;
   localparam logic [STEP_W-1:0] S_SUB      = 5'd4;
   localparam logic [STEP_W-1:0] S_MUL      = 5'd5;
   localparam logic [STEP_W-1:0] S_ZERO     = 5'd6;
   localparam logic [STEP_W-1:0] S_INV_A    = 5'd7;
   localparam logic [STEP_W-1:0] S_DIV      = 5'd8;
   localparam logic [STEP_W-1:0] S_POW      = 5'd9;
   localparam logic [STEP_W-1:0] S_POW_POS  = 5'd10;
   localparam logic [STEP_W-1:0] S_POW_NEG  = 5'd11;
   localparam logic [STEP_W-1:0] S_SRCH     = 5'd12;
   localparam logic [STEP_W-1:0] S_TEST     = 5'd13;
   localparam logic [STEP_W-1:0] S_TRY      = 5'd14;
   localparam logic [STEP_W-1:0] S_CHK      = 5'd15;
   localparam logic [STEP_W-1:0] S_INC      = 5'd16;
   localparam logic [STEP_W-1:0] S_FOUND    = 5'd17;
   localparam logic [STEP_W-1:0] S_POST     = 5'd18;
   localparam logic [STEP_W-1:0] S_POST_INV = 5'd19;
   localparam logic [STEP_W-1:0] S_POST_DIV = 5'd20;
   localparam logic [STEP_W-1:0] S_POST_POW = 5'd21;
   localparam logic [STEP_W-1:0] S_PLOOP    = 5'd22;
   localparam logic [STEP_W-1:0] S_PBIT     = 5'd23;
   localparam logic [STEP_W-1:0] S_PMUL     = 5'd24;
   localparam logic [STEP_W-1:0] S_PSQ      = 5'd25;
   localparam logic [STEP_W-1:0] S_OUT      = 5'd26;

   // Datapath operation of one step
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,      // capture input item
      OP_A_RED,     // a = a mod M
      OP_B_RED,     // b = b mod M
      OP_ADD,       // acc = a + b mod M
      OP_SUB,       // acc = a - b mod M
      OP_ACC_MUL,   // acc = a * b mod M
      OP_ZERO,      // acc = 0
      OP_V_A,       // search value = a
      OP_V_B,       // search value = b
      OP_POW_POS,   // base = a, acc = 1
      OP_POW_NEG,   // e = -e, acc = 1, search value = a
      OP_I_INIT,    // i = 1, inv = 0
      OP_T_MUL,     // t = v * i mod M
      OP_I_INC,     // i = i + 1
      OP_INV_I,     // inv = i
      OP_ACC_INV,   // acc = inv
      OP_DIV_MUL,   // acc = a * inv mod M
      OP_BASE_INV,  // base = inv
      OP_PMUL,      // acc = acc * base mod M
      OP_BASE_SQ,   // base = base * base mod M, e >>= 1
      OP_OUT        // load result register
   } mra_op_type;

   // What a step waits on before it completes
   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_MUL,
      WAIT_RSP
   } mra_wait_type;

   // How the step counter moves after a step completes
   typedef enum logic [3:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_MODE,
      JMP_POST,
      JMP_IF_END,
      JMP_IF_ONE,
      JMP_IF_EZERO,
      JMP_IF_ELSB0,
      JMP_IF_ENEG
   } mra_jump_type;

   typedef struct packed {
      mra_op_type          op;
      mra_wait_type        wait_sel;
      mra_jump_type        jump;
      logic [STEP_W-1:0]   target;
   } mra_ucode_type;

   // Sequencer to datapath
   typedef struct packed {
      mra_op_type op;
      logic       commit;
      logic       mul_run;
      logic       req_open;
   } mra_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic       rsp_free;
      logic       mul_done;
      logic       e_neg;
      logic       e_zero;
      logic       e_lsb;
      logic       i_end;
      logic       t_one;
      logic [2:0] mode;
   } mra_status_type;

   function automatic mra_ucode_type mra_uc(mra_op_type op, mra_wait_type w,
                                            mra_jump_type j,
                                            logic [STEP_W-1:0] t);
      mra_ucode_type u;
      u.op       = op;
      u.wait_sel = w;
      u.jump     = j;
      u.target   = t;
      return u;
   endfunction

   // Control store
   function automatic mra_ucode_type mra_ucode(logic [STEP_W-1:0] addr);
      mra_ucode_type u;
      unique case (addr)
         S_IDLE:     u = mra_uc(OP_LOAD,     WAIT_REQ,  JMP_NEXT,     S_IDLE);
         S_RED_A:    u = mra_uc(OP_A_RED,    WAIT_NONE, JMP_NEXT,     S_IDLE);
         S_RED_B:    u = mra_uc(OP_B_RED,    WAIT_NONE, JMP_MODE,     S_IDLE);
         S_ADD:      u = mra_uc(OP_ADD,      WAIT_NONE, JMP_ALWAYS,   S_OUT);
         S_SUB:      u = mra_uc(OP_SUB,      WAIT_NONE, JMP_ALWAYS,   S_OUT);
         S_MUL:      u = mra_uc(OP_ACC_MUL,  WAIT_MUL,  JMP_ALWAYS,   S_OUT);
         S_ZERO:     u = mra_uc(OP_ZERO,     WAIT_NONE, JMP_ALWAYS,   S_OUT);
         S_INV_A:    u = mra_uc(OP_V_A,      WAIT_NONE, JMP_ALWAYS,   S_SRCH);
         S_DIV:      u = mra_uc(OP_V_B,      WAIT_NONE, JMP_ALWAYS,   S_SRCH);
         S_POW:      u = mra_uc(OP_NONE,     WAIT_NONE, JMP_IF_ENEG,  S_POW_NEG);
         S_POW_POS:  u = mra_uc(OP_POW_POS,  WAIT_NONE, JMP_ALWAYS,   S_PLOOP);
         S_POW_NEG:  u = mra_uc(OP_POW_NEG,  WAIT_NONE, JMP_ALWAYS,   S_SRCH);
         S_SRCH:     u = mra_uc(OP_I_INIT,   WAIT_NONE, JMP_NEXT,     S_IDLE);
         S_TEST:     u = mra_uc(OP_NONE,     WAIT_NONE, JMP_IF_END,   S_POST);
         S_TRY:      u = mra_uc(OP_T_MUL,    WAIT_MUL,  JMP_NEXT,     S_IDLE);
         S_CHK:      u = mra_uc(OP_NONE,     WAIT_NONE, JMP_IF_ONE,   S_FOUND);
         S_INC:      u = mra_uc(OP_I_INC,    WAIT_NONE, JMP_ALWAYS,   S_TEST);
         S_FOUND:    u = mra_uc(OP_INV_I,    WAIT_NONE, JMP_NEXT,     S_IDLE);
         S_POST:     u = mra_uc(OP_NONE,     WAIT_NONE, JMP_POST,     S_IDLE);
         S_POST_INV: u = mra_uc(OP_ACC_INV,  WAIT_NONE, JMP_ALWAYS,   S_OUT);
         S_POST_DIV: u = mra_uc(OP_DIV_MUL,  WAIT_MUL,  JMP_ALWAYS,   S_OUT);
         S_POST_POW: u = mra_uc(OP_BASE_INV, WAIT_NONE, JMP_ALWAYS,   S_PLOOP);
         S_PLOOP:    u = mra_uc(OP_NONE,     WAIT_NONE, JMP_IF_EZERO, S_OUT);
         S_PBIT:     u = mra_uc(OP_NONE,     WAIT_NONE, JMP_IF_ELSB0, S_PSQ);
         S_PMUL:     u = mra_uc(OP_PMUL,     WAIT_MUL,  JMP_NEXT,     S_IDLE);
         S_PSQ:      u = mra_uc(OP_BASE_SQ,  WAIT_MUL,  JMP_ALWAYS,   S_PLOOP);
         S_OUT:      u = mra_uc(OP_OUT,      WAIT_RSP,  JMP_ALWAYS,   S_IDLE);
         default:    u = mra_uc(OP_NONE,     WAIT_NONE, JMP_ALWAYS,   S_IDLE);
      endcase
      return u;
   endfunction

   // Entry step per mode after operand reduction
   function automatic logic [STEP_W-1:0] mra_mode_entry(logic [2:0] mode);
      logic [STEP_W-1:0] s;
      unique case (mode)
         MODE_ADD: s = S_ADD;
         MODE_SUB: s = S_SUB;
         MODE_MUL: s = S_MUL;
         MODE_POW: s = S_POW;
         MODE_INV: s = S_INV_A;
         MODE_DIV: s = S_DIV;
         default:  s = S_ZERO;
      endcase
      return s;
   endfunction

   // Return point per mode once the inverse search has finished
   function automatic logic [STEP_W-1:0] mra_post_entry(logic [2:0] mode);
      logic [STEP_W-1:0] s;
      unique case (mode)
         MODE_POW: s = S_POST_POW;
         MODE_DIV: s = S_POST_DIV;
         default:  s = S_POST_INV;
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/modular_residue_alu.sv */
// Top level of the modular residue ALU: sequencer, datapath and checks.
//
// Usage: one item on the req_ channel (mode, operand_a, operand_b, exponent)
// gives one residue on the rsp_ channel. Modes: add, subtract, multiply,
// power, inverse of operand_a, divide; other mode codes give 0.
// A microprogram steps a shared bit-serial modular multiplier; its y operand
// is Y = max(5, bits to hold MODULUS) bits wide, 5 at the default.
// Add, subtract and unused modes need no multiply; multiply uses one.
// Inverse searches i = 1, 2, ... for a*i == 1 and gives 0 when none is found;
// divide multiplies operand_a by the inverse of operand_b.
// Power squares and multiplies over the bits of |exponent| up to its top set
// bit; a negative exponent first runs the inverse search on operand_a.
// One item is in flight at a time; req_stall is high from accept until the
// result is loaded into the output register, so the next item is taken while
// that result waits. A stalled result holds, and a new result then waits
// behind it. Synchronous reset clears the step counter, the multiplier and
// the output valid flag.
module modular_residue_alu
   import mra_pkg::*;
#(
   parameter int MODULUS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [4:0]  req_operand_a,
   input  logic [4:0]  req_operand_b,
   input  logic [31:0] req_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_result
);

   mra_ctrl_type   ctrl;
   mra_status_type status;

   mra_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   mra_datapath #(
      .MODULUS (MODULUS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_exponent  (req_exponent),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   assign req_stall = !ctrl.req_open;

`ifndef ASSERT_OFF
   // An accepted item closes the input until its result is produced
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after accept");

   // Results are reduced residues
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MODULUS > 31 || rsp_result < MODULUS))
      else $error("result not below modulus");

   // Multiplier completes only in a step that waits on it
   a_mul_in_step: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> ctrl.mul_run)
      else $error("multiplier done outside a multiply step");
`endif

endmodule

/* hw/rtl/mra_mulmod.sv */
// Bit-serial modular multiplier: x * y mod MODULUS, one bit of y per cycle.
module mra_mulmod
   import mra_pkg::*;
#(
   parameter int MODULUS = 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [$clog2(MODULUS)-1:0]         x,
   input  logic [((($clog2(MODULUS+1)) > 5) ? $clog2(MODULUS+1) : 5)-1:0] y,
   output logic                               busy,
   output logic                               done,
   output logic [$clog2(MODULUS)-1:0]         product
);

   localparam int W  = $clog2(MODULUS);
   localparam int IW = $clog2(MODULUS + 1);
   localparam int YW = (IW > 5) ? IW : 5;
   localparam int CW = $clog2(YW + 1);
   localparam logic [W:0] MOD_C = (W + 1)'(MODULUS);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    dbl, dbl_r, sum, sum_r;

   // One MSB-first step: acc = 2*acc + bit*x, each part folded below M
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= MOD_C) ? dbl - MOD_C : dbl;
      sum   = {1'b0, dbl_r[W-1:0]} + (y_ff[YW-1] ? {1'b0, x_ff} : '0);
      sum_r = (sum >= MOD_C) ? sum - MOD_C : sum;
   end

   assign product = sum_r[W-1:0];
   assign done    = busy_ff && (cnt_ff == CW'(1));
   assign busy    = busy_ff;

   // Next-state of the iteration registers
   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start && !busy_ff) begin
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         cnt_in  = CW'(YW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = product;
         y_in   = y_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

/* hw/rtl/mra_datapath.sv */
// Operand, accumulator and search registers of the residue ALU, plus result register.
module mra_datapath
   import mra_pkg::*;
#(
   parameter int MODULUS = 31
) (
   input  logic           clock,
   input  logic           reset,
   input  mra_ctrl_type   ctrl,
   input  logic [2:0]     req_mode,
   input  logic [4:0]     req_operand_a,
   input  logic [4:0]     req_operand_b,
   input  logic [31:0]    req_exponent,
   output mra_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [4:0]     rsp_result
);

   localparam int W  = $clog2(MODULUS);
   localparam int IW = $clog2(MODULUS + 1);
   localparam int YW = (IW > 5) ? IW : 5;
   localparam int RW = (W > 5) ? W : 5;
   localparam logic [W:0] MOD_C = (W + 1)'(MODULUS);

   logic [2:0]    mode_ff, mode_in;
   logic [YW-1:0] a_ff, a_in, b_ff, b_in;
   logic [31:0]   e_ff, e_in;
   logic [W-1:0]  acc_ff, acc_in, base_ff, base_in, v_ff, v_in;
   logic [W-1:0]  inv_ff, inv_in, t_ff, t_in;
   logic [IW-1:0] i_ff, i_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    rsp_result_ff, rsp_result_in;

   logic [W-1:0]  mul_x, mul_prod;
   logic [YW-1:0] mul_y;
   logic          mul_busy, mul_done;
   logic [W:0]    add_raw, add_mod, sub_mod;
   logic [RW-1:0] acc_ext;

   // 5-bit operand reduced below the modulus: a 32-entry constant table
   function automatic logic [YW-1:0] reduce_operand(logic [4:0] v);
      logic [YW-1:0] r;
      r = '0;
      for (int k = 0; k < 32; k++) begin
         if (v == 5'(k)) begin
            r = YW'(k % MODULUS);
         end
      end
      return r;
   endfunction

   // Multiplier operand select per operation
   always_comb begin
      unique case (ctrl.op)
         OP_ACC_MUL: begin mul_x = a_ff[W-1:0]; mul_y = b_ff;         end
         OP_T_MUL:   begin mul_x = v_ff;        mul_y = YW'(i_ff);    end
         OP_DIV_MUL: begin mul_x = a_ff[W-1:0]; mul_y = YW'(inv_ff);  end
         OP_PMUL:    begin mul_x = acc_ff;      mul_y = YW'(base_ff); end
         OP_BASE_SQ: begin mul_x = base_ff;     mul_y = YW'(base_ff); end
         default:    begin mul_x = '0;          mul_y = '0;           end
      endcase
   end

   mra_mulmod #(
      .MODULUS (MODULUS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.mul_run && !mul_busy),
      .x       (mul_x),
      .y       (mul_y),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Modular add and subtract on reduced operands
   always_comb begin
      add_raw = {1'b0, a_ff[W-1:0]} + {1'b0, b_ff[W-1:0]};
      add_mod = (add_raw >= MOD_C) ? add_raw - MOD_C : add_raw;
      if (a_ff[W-1:0] >= b_ff[W-1:0]) begin
         sub_mod = {1'b0, a_ff[W-1:0]} - {1'b0, b_ff[W-1:0]};
      end else begin
         sub_mod = {1'b0, a_ff[W-1:0]} + MOD_C - {1'b0, b_ff[W-1:0]};
      end
   end

   assign acc_ext = RW'(acc_ff);

   // Register updates, taken when the current step completes
   always_comb begin
      mode_in       = mode_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      e_in          = e_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      v_in          = v_ff;
      inv_in        = inv_ff;
      t_in          = t_ff;
      i_in          = i_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (ctrl.commit) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               mode_in = req_mode;
               a_in    = YW'(req_operand_a);
               b_in    = YW'(req_operand_b);
               e_in    = req_exponent;
            end
            OP_A_RED:   a_in = reduce_operand(a_ff[4:0]);
            OP_B_RED:   b_in = reduce_operand(b_ff[4:0]);
            OP_ADD:     acc_in = add_mod[W-1:0];
            OP_SUB:     acc_in = sub_mod[W-1:0];
            OP_ACC_MUL: acc_in = mul_prod;
            OP_ZERO:    acc_in = '0;
            OP_V_A:     v_in = a_ff[W-1:0];
            OP_V_B:     v_in = b_ff[W-1:0];
            OP_POW_POS: begin
               base_in = a_ff[W-1:0];
               acc_in  = W'(1);
            end
            OP_POW_NEG: begin
               e_in   = ~e_ff + 32'd1;
               acc_in = W'(1);
               v_in   = a_ff[W-1:0];
            end
            OP_I_INIT: begin
               i_in   = IW'(1);
               inv_in = '0;
            end
            OP_T_MUL:    t_in = mul_prod;
            OP_I_INC:    i_in = i_ff + IW'(1);
            OP_INV_I:    inv_in = i_ff[W-1:0];
            OP_ACC_INV:  acc_in = inv_ff;
            OP_DIV_MUL:  acc_in = mul_prod;
            OP_BASE_INV: base_in = inv_ff;
            OP_PMUL:     acc_in = mul_prod;
            OP_BASE_SQ: begin
               base_in = mul_prod;
               e_in    = e_ff >> 1;
            end
            OP_OUT: begin
               rsp_result_in = acc_ext[4:0];
               rsp_valid_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      v_ff          <= v_in;
      inv_ff        <= inv_in;
      t_ff          <= t_in;
      i_ff          <= i_in;
      rsp_result_ff <= rsp_result_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Flags for the sequencer's conditional jumps
   always_comb begin
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
      status.mul_done = mul_done;
      status.e_neg    = e_ff[31];
      status.e_zero   = (e_ff == 32'd0);
      status.e_lsb    = e_ff[0];
      status.i_end    = (i_ff == IW'(MODULUS));
      status.t_one    = (t_ff == W'(1));
      status.mode     = mode_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

/* hw/rtl/mra_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and jump selection.
module mra_sequencer
   import mra_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  mra_status_type status,
   output mra_ctrl_type   ctrl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] dest;
   mra_ucode_type     uword;
   logic              done_step;
   logic              take;

   assign uword = mra_ucode(step_ff);

   // Step completion
   always_comb begin
      unique case (uword.wait_sel)
         WAIT_NONE: done_step = 1'b1;
         WAIT_REQ:  done_step = req_valid;
         WAIT_MUL:  done_step = status.mul_done;
         WAIT_RSP:  done_step = status.rsp_free;
         default:   done_step = 1'b0;
      endcase
   end

   // Branch condition and destination
   always_comb begin
      dest = uword.target;
      unique case (uword.jump)
         JMP_NEXT:     take = 1'b0;
         JMP_ALWAYS:   take = 1'b1;
         JMP_MODE: begin
            take = 1'b1;
            dest = mra_mode_entry(status.mode);
         end
         JMP_POST: begin
            take = 1'b1;
            dest = mra_post_entry(status.mode);
         end
         JMP_IF_END:   take = status.i_end;
         JMP_IF_ONE:   take = status.t_one;
         JMP_IF_EZERO: take = status.e_zero;
         JMP_IF_ELSB0: take = !status.e_lsb;
         JMP_IF_ENEG:  take = status.e_neg;
         default:      take = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (done_step) begin
         step_in = take ? dest : step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl.op       = uword.op;
      ctrl.commit   = done_step;
      ctrl.mul_run  = (uword.wait_sel == WAIT_MUL);
      ctrl.req_open = (uword.wait_sel == WAIT_REQ);
   end

endmodule

/* dv/mra_checker.sv */
// Checker for the modular residue ALU: predicts each item's residue and compares results.
module mra_checker
   import mra_pkg::*;
#(
   parameter int MODULUS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [4:0]  req_operand_a,
   input  logic [4:0]  req_operand_b,
   input  logic [31:0] req_exponent,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_result,
   output int          fail_count,
   output int          pending_count
);

   // Residues still owed by the block, oldest first
   logic [4:0] expected_residues[$];

   function automatic int unsigned residue(longint unsigned v);
      return int'(v % longint'(MODULUS));
   endfunction

   function automatic int unsigned mul_mod(int unsigned p, int unsigned q);
      return residue(longint'(p) * longint'(q));
   endfunction

   // Least i in 1..MODULUS-1 with v*i == 1, else 0
   function automatic int unsigned inverse_of(int unsigned v);
      for (int unsigned i = 1; i < MODULUS; i++) begin
         if (mul_mod(v, i) == 1) return i;
      end
      return 0;
   endfunction

   // Square-and-multiply; a negative exponent raises the inverse to |e|
   function automatic int unsigned power_of(int unsigned base, logic [31:0] e);
      int unsigned acc;
      int unsigned sq;
      logic [31:0] count;
      acc   = residue(1);
      sq    = base;
      count = e;
      if (e[31]) begin
         count = -e;   // -2^31 wraps to 2^31 as an unsigned magnitude
         sq    = inverse_of(base);
      end
      while (count != 0) begin
         if (count[0]) acc = mul_mod(acc, sq);
         sq    = mul_mod(sq, sq);
         count = count >> 1;
      end
      return acc;
   endfunction

   function automatic logic [4:0] predict_result(logic [2:0] mode, logic [4:0] opa,
                                                 logic [4:0] opb, logic [31:0] e);
      int unsigned a;
      int unsigned b;
      int unsigned r;
      a = residue(opa);
      b = residue(opb);
      case (mode)
         MODE_ADD: r = residue(a + b);
         MODE_SUB: r = residue(a + MODULUS - b);
         MODE_MUL: r = mul_mod(a, b);
         MODE_POW: r = power_of(a, e);
         MODE_INV: r = inverse_of(a);
         MODE_DIV: r = mul_mod(a, inverse_of(b));
         default:  r = 0;
      endcase
      return r[4:0];
   endfunction

   // Push a prediction per accepted item, compare per accepted result
   always @(posedge clock) begin : watch
      logic [4:0] want;
      if (reset) begin
         expected_residues.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_residues.push_back(predict_result(req_mode, req_operand_a,
                                                       req_operand_b, req_exponent));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_residues.size() == 0) begin
               $error("result: no item outstanding, actual %0d", rsp_result);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_residues.pop_front();
               if (rsp_result !== want) begin
                  $error("result: expected %0d, actual %0d", want, rsp_result);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_residues.size();
      end
   end

endmodule

/* dv/tb_top.sv */
// Testbench top for the modular residue ALU: clock, reset, stimulus and verdict.
module tb_top
   import mra_pkg::*;
();

   // Mode codes the block maps to a zero result
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   localparam int RANDOM_ITEMS = 1200;
   localparam int LONG_HOLD    = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [4:0]  req_operand_a = '0;
   logic [4:0]  req_operand_b = '0;
   logic [31:0] req_exponent = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_result;

   int fail_count;
   int pending_count;
   bit no_gaps = 1'b0;
   bit hold_request = 1'b0;

   modular_residue_alu u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_exponent  (req_exponent),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   mra_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_exponent  (req_exponent),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_len(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // Mostly reduced operands, sometimes the unreduced value 31
   function automatic logic [4:0] rand_residue();
      if ($urandom_range(0, 19) == 0) return 5'd31;
      return 5'($urandom_range(0, 30));
   endfunction

   function automatic logic [31:0] rand_exponent();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = $urandom_range(0, 80);
            return v - 32'd40;
         end
         4, 5, 6: return $urandom;
         7: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         default: begin
            v = $urandom_range(0, 65535);
            if ($urandom_range(0, 1) == 1) v = -v;
            return v;
         end
      endcase
   endfunction

   // Offer one item after a random gap and hold it until accepted.
   // Called and returns at a falling edge.
   task automatic send_item(input logic [2:0] m, input logic [4:0] a,
                            input logic [4:0] b, input logic [31:0] e);
      int gap;
      gap = idle_len(no_gaps);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_operand_a <= a;
      req_operand_b <= b;
      req_exponent  <= e;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Wait at a falling edge until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   // Result side: random stall runs, free stretches, one long hold-off
   initial begin : result_side
      int run;
      int gap;
      forever begin
         run = $urandom_range(1, 8);
         if ($urandom_range(0, 9) == 0) run = $urandom_range(100, 400);
         rsp_stall <= 1'b0;
         repeat (run) @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            gap = idle_len(1'b0);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #96_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [2:0] m;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every mode, special cases
      send_item(MODE_ADD, 5'd30, 5'd30, 32'h0);
      send_item(MODE_ADD, 5'd0, 5'd0, 32'hFFFF_FFFF);
      send_item(MODE_SUB, 5'd0, 5'd30, 32'h0);
      send_item(MODE_SUB, 5'd30, 5'd0, 32'h0);
      send_item(MODE_MUL, 5'd30, 5'd30, 32'h0);
      send_item(MODE_MUL, 5'd0, 5'd17, 32'h0);
      // zero exponent gives 1 even for base 0
      send_item(MODE_POW, 5'd0, 5'd0, 32'h0);
      send_item(MODE_POW, 5'd3, 5'd0, 32'h7FFF_FFFF);
      // most negative exponent has magnitude 2^31
      send_item(MODE_POW, 5'd3, 5'd0, 32'h8000_0000);
      // negative exponent on a base with no inverse
      send_item(MODE_POW, 5'd0, 5'd0, 32'hFFFF_FFFF);
      send_item(MODE_POW, 5'd5, 5'd0, 32'hFFFF_FFFF);
      send_item(MODE_POW, 5'd30, 5'd31, 32'h1);
      send_item(MODE_INV, 5'd0, 5'd0, 32'h0);
      send_item(MODE_INV, 5'd1, 5'd0, 32'h0);
      send_item(MODE_INV, 5'd30, 5'd0, 32'h0);
      // division by zero
      send_item(MODE_DIV, 5'd7, 5'd0, 32'h0);
      send_item(MODE_DIV, 5'd30, 5'd30, 32'h0);
      send_item(MODE_SPARE6, 5'd12, 5'd9, 32'h5);
      send_item(MODE_SPARE7, 5'd31, 5'd31, 32'hFFFF_FFFF);
      // unreduced operands
      send_item(MODE_ADD, 5'd31, 5'd31, 32'h0);
      send_item(MODE_INV, 5'd31, 5'd0, 32'h0);
      send_item(MODE_POW, 5'd31, 5'd0, 32'h5);
      send_item(MODE_DIV, 5'd31, 5'd31, 32'h0);
      send_item(MODE_MUL, 5'd31, 5'd5, 32'h0);
      drain_results();

      // Random items
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gaps = ((n % 200) < 40);
         if (n == 300) hold_request = 1'b1;
         if (n == 600) drain_results();
         if ($urandom_range(0, 19) == 0) m = 3'($urandom_range(6, 7));
         else m = 3'($urandom_range(0, 5));
         send_item(m, rand_residue(), rand_residue(),
                   (m == MODE_POW) ? rand_exponent() : $urandom);
      end
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
